// File: src/binary_heap_priority_queue_assert.svh
// Assertion macros for the heap priority queue.
// BHPQ_ASSERT checks a property at every rising clock edge outside reset.
// BHPQ_ASSERT_NEXT checks that a condition holds in the cycle after a trigger.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define BHPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BHPQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BHPQ_ASSERT(lbl, clk, rst, prop, msg)
`define BHPQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// File: src/bhpq_pkg.sv
`default_nettype none
package bhpq_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = ADDR_W + 2;
   localparam int KEY_W    = 32;
   localparam int STAT_W   = 2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [STAT_W-1:0]       status_type;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   localparam key_type KEY_EMPTY = '1;
   localparam key_type KEY_NONE  = '0;

   typedef struct packed {
      logic    op;
      key_type key;
   } req_item_type;

   typedef struct packed {
      key_type    key;
      status_type status;
   } rsp_item_type;

   // true when key a must sit above key b: mode 0 min-heap, mode 1 max-heap
   function automatic logic ranks_before(key_type a, key_type b, logic mode);
      return mode ? (a > b) : (a < b);
   endfunction

endpackage
`default_nettype wire

// File: src/binary_heap_priority_queue.sv
// Priority queue of signed 32-bit keys kept as a binary heap in one memory.
// Request channel: req_tuser selects insert (0) or extract (1), req_tdata
// carries the key for an insert. Every request yields exactly one response
// on the rsp channel: rsp_tdata is the extracted key (0 for an insert, -1 for
// an extract from an empty heap), rsp_tuser the status (0 ok, 1 full, 2 empty).
// csr_wr_en/csr_wr_data write the ordering bit: 0 min-heap, 1 max-heap. Write
// it only while no request is in flight; stored keys are not reordered.
// One request is worked at a time. Each heap level has a read step that
// fetches the parent or both children from the memory and a compare step
// that compares and moves an entry. A full insert or an empty extract goes
// straight to its response without a sift. With the receiver ready the
// next request is accepted in the same cycle as rsp_tvalid rises.
// A finished response sits in an output register, so the next request is
// accepted while the receiver stalls; a second response then waits inside.
// Reset empties the heap, clears the ordering bit to min-heap and drops any
// pending response. The key memory needs no clearing pass.
`default_nettype none
module binary_heap_priority_queue (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire [bhpq_pkg::KEY_W-1:0]     req_tdata,   // [31:0] key_in
   input  wire                           req_tuser,   // [0] req_type
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [bhpq_pkg::KEY_W-1:0]    rsp_tdata,   // [31:0] key_out
   output logic [bhpq_pkg::STAT_W-1:0]   rsp_tuser,   // [1:0] status
   input  wire                           csr_wr_en,
   input  wire                           csr_wr_data
);
   import bhpq_pkg::*;

   logic         order_mode_ff, order_mode_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic         start;
   logic         sift_idle;
   logic         res_valid;
   logic         res_ready;
   req_item_type req;
   rsp_item_type res;

   assign req.op  = req_tuser;
   assign req.key = req_tdata;
   assign req_tready = sift_idle;
   assign start      = req_tvalid && sift_idle;

   bhpq_sift u_sift (
      .clock      (clock),
      .reset      (reset),
      .order_mode (order_mode_ff),
      .start      (start),
      .req        (req),
      .idle       (sift_idle),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // load the output register when it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      order_mode_in = csr_wr_en ? csr_wr_data : order_mode_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         order_mode_ff <= order_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff.key;
   assign rsp_tuser  = rsp_item_ff.status;

endmodule
`default_nettype wire

// File: src/bhpq_store.sv
`default_nettype none
module bhpq_store (
   input  wire                clock,
   input  wire                wr_en,
   input  bhpq_pkg::addr_type wr_addr,
   input  bhpq_pkg::key_type  wr_data,
   input  bhpq_pkg::addr_type rd_addr_a,
   input  bhpq_pkg::addr_type rd_addr_b,
   output bhpq_pkg::key_type  rd_data_a,
   output bhpq_pkg::key_type  rd_data_b
);
   import bhpq_pkg::*;

   key_type store_ff [CAPACITY];
   key_type rd_a_ff;
   key_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= store_ff[rd_addr_a];
      rd_b_ff <= store_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// File: src/bhpq_sift.sv
`default_nettype none
`include "binary_heap_priority_queue_assert.svh"
module bhpq_sift (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    order_mode,
   input  wire                    start,
   input  bhpq_pkg::req_item_type req,
   output logic                   idle,
   output logic                   res_valid,
   input  wire                    res_ready,
   output bhpq_pkg::rsp_item_type res
);
   import bhpq_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP_RD   = 3'd1;
   localparam logic [2:0] S_UP_CMP  = 3'd2;
   localparam logic [2:0] S_DN_LOAD = 3'd3;
   localparam logic [2:0] S_DN_RD   = 3'd4;
   localparam logic [2:0] S_DN_CMP  = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;
   addr_type   pos_ff, pos_in;
   count_type  count_ff, count_in;
   key_type    key_ff, key_in;
   key_type    res_key_ff, res_key_in;
   status_type res_status_ff, res_status_in;

   logic                wr_en;
   addr_type            wr_addr;
   key_type             wr_data;
   addr_type            rd_addr_a;
   addr_type            rd_addr_b;
   key_type             rd_data_a;
   key_type             rd_data_b;

   count_type           last_idx;
   addr_type            parent;
   logic [CHILD_W-1:0]  left_idx;
   logic [CHILD_W-1:0]  right_idx;
   logic                take_left;
   logic                take_right;
   key_type             best_key;

   bhpq_store u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign last_idx  = count_ff - CNT_W'(1);
   assign parent    = addr_type'(pos_ff - ADDR_W'(1)) >> 1;
   assign left_idx  = CHILD_W'({pos_ff, 1'b1});
   assign right_idx = left_idx + CHILD_W'(1);

   // left child wins a tie: right must beat the better of key and left
   assign take_left  = (left_idx < CHILD_W'(count_ff))
                       && ranks_before(rd_data_a, key_ff, order_mode);
   assign best_key   = take_left ? rd_data_a : key_ff;
   assign take_right = (right_idx < CHILD_W'(count_ff))
                       && ranks_before(rd_data_b, best_key, order_mode);

   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      case (state_ff)
         S_IDLE: begin
            rd_addr_b = last_idx[ADDR_W-1:0];
         end
         S_UP_RD: begin
            rd_addr_a = parent;
         end
         S_DN_RD: begin
            rd_addr_a = left_idx[ADDR_W-1:0];
            rd_addr_b = right_idx[ADDR_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = key_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_key_in    = KEY_NONE;
               res_status_in = ST_OK;
               if (req.op == OP_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     pos_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     key_in   = req.key;
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_key_in    = KEY_EMPTY;
                     res_status_in = ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     count_in = last_idx;
                     state_in = S_DN_LOAD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (ranks_before(key_ff, rd_data_a, order_mode)) begin
               // move the parent down into the hole
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN_LOAD: begin
            res_key_in = rd_data_a;
            key_in     = rd_data_b;
            pos_in     = '0;
            state_in   = (count_ff == '0) ? S_DONE : S_DN_RD;
         end
         S_DN_RD: begin
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (take_right) begin
               wr_data  = rd_data_b;
               pos_in   = right_idx[ADDR_W-1:0];
               state_in = S_DN_RD;
            end else if (take_left) begin
               wr_data  = rd_data_a;
               pos_in   = left_idx[ADDR_W-1:0];
               state_in = S_DN_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_DONE);
   assign res.key    = res_key_ff;
   assign res.status = res_status_ff;

   `BHPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `BHPQ_ASSERT(a_start_idle, clock, reset, !start || state_ff == S_IDLE, "request taken while busy")
   `BHPQ_ASSERT(a_write_in_heap, clock, reset, !wr_en || CNT_W'(wr_addr) < count_ff, "write beyond fill")
   `BHPQ_ASSERT(a_empty_key, clock, reset, !(res_valid && res.status == ST_EMPTY) || res.key == KEY_EMPTY, "empty extract key")
   `BHPQ_ASSERT_NEXT(a_insert_count, clock, reset, start && req.op == OP_INSERT && count_ff != CNT_W'(CAPACITY), count_ff == CNT_W'($past(count_ff) + CNT_W'(1)), "insert did not grow heap")

endmodule
`default_nettype wire
